[rtl/core/vbnm_pkg.sv]
package vbnm_pkg;

    localparam int TABLE_RAM_BYTES = 2048;
    localparam int TABLE_ADDR_W    = $clog2(TABLE_RAM_BYTES);
    localparam int ADDR_W          = 14;
    localparam int DATA_W          = 8;
    localparam int OFFSET_W        = 10;
    localparam int PAL_ADDR_W      = 5;
    localparam int PAL_DEPTH       = 1 << PAL_ADDR_W;

    localparam logic [ADDR_W-1:0] PATTERN_END   = 14'h2000;
    localparam logic [ADDR_W-1:0] TABLE_END     = 14'h3EFF;
    localparam logic [ADDR_W-1:0] PALETTE_ALIAS = 14'h3F10;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        MIR_HORIZONTAL   = 2'd0,
        MIR_VERTICAL     = 2'd1,
        MIR_SINGLE_LOWER = 2'd2,
        MIR_SINGLE_UPPER = 2'd3
    } mirror_t;

    typedef enum logic [1:0] {
        SRC_ZERO    = 2'd0,
        SRC_TABLE   = 2'd1,
        SRC_PALETTE = 2'd2
    } rd_src_t;

    typedef enum logic [1:0] {
        ST_CLEAR  = 2'd0,
        ST_IDLE   = 2'd1,
        ST_ACCESS = 2'd2
    } ctrl_state_t;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic              chr_access;
        logic              a12_level;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic load_out;
        logic clear_en;
    } vbnm_cmd_t;

    typedef struct packed {
        logic clear_last;
    } vbnm_status_t;

endpackage

[rtl/core/video_bus_nametable_mirror_decode.sv]
// Video bus decoder: pattern region (below 0x2000) is only flagged, 0x2000-0x3EFF maps
// four name tables onto two 1 KiB banks of table RAM per mirror_mode, 0x3F00-0x3FFF hits
// the 32-byte palette (a write to 0x3F10 lands in entry 0). After reset the table RAM is
// zeroed by a sweep over all TABLE_RAM_BYTES (2048) addresses with in_stall high; config writes
// are taken during it. Each access then has a transfer cycle with the registered RAM/palette
// read, then the load of the output register, which waits while out_stall holds the last
// result. An access may be taken while the previous result still waits on out_stall.
module video_bus_nametable_mirror_decode
    import vbnm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_data
);

    vbnm_cmd_t    cmd;
    vbnm_status_t status;

    vbnm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    vbnm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .out_data  (out_data)
    );

endmodule

[rtl/core/vbnm_datapath.sv]
module vbnm_datapath
    import vbnm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  vbnm_cmd_t           cmd,
    output vbnm_status_t        status,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_wdata,
    input  in_item_t            in_data,
    output out_item_t           out_data
);

    mirror_t                   mirror_reg;
    logic [TABLE_ADDR_W-1:0]   clr_cnt_reg;
    logic [TABLE_ADDR_W-1:0]   clr_cnt_next;

    logic [DATA_W-1:0]         table_ram [TABLE_RAM_BYTES];
    logic [DATA_W-1:0]         pal_reg [PAL_DEPTH];

    logic [DATA_W-1:0]         tbl_rd_reg;
    logic [DATA_W-1:0]         pal_rd_reg;
    rd_src_t                   src_reg;
    rd_src_t                   src_next;
    logic                      chr_reg;
    logic                      a12_reg;
    out_item_t                 out_reg;
    out_item_t                 out_next;

    logic                      is_chr;
    logic                      is_table;
    logic                      is_write;
    logic [1:0]                tbl_sel;
    logic                      bank;
    logic [TABLE_ADDR_W-1:0]   tbl_idx;
    logic [PAL_ADDR_W-1:0]     pal_widx;
    logic                      tbl_we;
    logic                      pal_we;
    logic [TABLE_ADDR_W-1:0]   ram_waddr;
    logic [DATA_W-1:0]         ram_wdata;
    logic                      ram_we;
    logic [DATA_W-1:0]         rdata_sel;

    // region decode
    assign is_chr   = in_data.addr < PATTERN_END;
    assign is_table = !is_chr && (in_data.addr <= TABLE_END);
    assign is_write = in_data.op == OP_WRITE;
    assign tbl_sel  = in_data.addr[OFFSET_W+1:OFFSET_W];

    always_comb
    begin
        unique case (mirror_reg)
            MIR_HORIZONTAL:   bank = tbl_sel[1];
            MIR_VERTICAL:     bank = tbl_sel[0];
            MIR_SINGLE_LOWER: bank = 1'b0;
            MIR_SINGLE_UPPER: bank = 1'b1;
            default:          bank = 1'b0;
        endcase
    end

    assign tbl_idx  = TABLE_ADDR_W'({bank, in_data.addr[OFFSET_W-1:0]});
    assign pal_widx = (in_data.addr == PALETTE_ALIAS) ? '0 : in_data.addr[PAL_ADDR_W-1:0];

    assign tbl_we = cmd.accept && is_write && is_table;
    assign pal_we = cmd.accept && is_write && !is_chr && !is_table;

    assign ram_we    = cmd.clear_en || tbl_we;
    assign ram_waddr = cmd.clear_en ? clr_cnt_reg : tbl_idx;
    assign ram_wdata = cmd.clear_en ? '0 : in_data.wdata;

    assign clr_cnt_next = cmd.clear_en ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
    assign status.clear_last = clr_cnt_reg == {TABLE_ADDR_W{1'b1}};

    always_comb
    begin
        if (is_write || is_chr)
            src_next = SRC_ZERO;
        else if (is_table)
            src_next = SRC_TABLE;
        else
            src_next = SRC_PALETTE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_reg  <= MIR_HORIZONTAL;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                mirror_reg <= mirror_t'(cfg_wdata);
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
            table_ram[ram_waddr] <= ram_wdata;
        if (cmd.accept)
            tbl_rd_reg <= table_ram[tbl_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAL_DEPTH; i++)
                pal_reg[i] <= '0;
        end
        else if (pal_we)
        begin
            pal_reg[pal_widx] <= in_data.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pal_rd_reg <= pal_reg[in_data.addr[PAL_ADDR_W-1:0]];
            src_reg    <= src_next;
            chr_reg    <= is_chr;
            a12_reg    <= in_data.addr[12];
        end
        out_reg <= out_next;
    end

    always_comb
    begin
        case (src_reg)
            SRC_TABLE:   rdata_sel = tbl_rd_reg;
            SRC_PALETTE: rdata_sel = pal_rd_reg;
            default:     rdata_sel = '0;
        endcase
    end

    always_comb
    begin
        out_next = out_reg;
        if (cmd.load_out)
        begin
            out_next.rdata      = rdata_sel;
            out_next.chr_access = chr_reg;
            out_next.a12_level  = a12_reg;
        end
    end

    assign out_data = out_reg;

endmodule

[rtl/core/vbnm_ctrl.sv]
module vbnm_ctrl
    import vbnm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output logic          out_valid,
    input  logic          out_stall,
    output vbnm_cmd_t     cmd,
    input  vbnm_status_t  status
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_ACCESS;
            end
            ST_ACCESS:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
                cmd.clear_en = 1'b1;
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            ST_ACCESS:
                cmd.load_out = out_free;
            default:
                in_stall = 1'b1;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over an untaken transfer");

    a_accept_to_access: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == ST_ACCESS))
        else $error("accepted transfer not followed by access");

    a_access_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACCESS) && !cmd.load_out |=> (state_reg == ST_ACCESS))
        else $error("access left without loading result");

    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) && status.clear_last |=> (state_reg == ST_IDLE))
        else $error("clear sweep did not end");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_en |-> !cmd.accept && in_stall)
        else $error("transfer accepted during clear sweep");
`endif

endmodule
